// ----- hdl/wpsl_pkg.sv -----
package wpsl_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = IDX_W + 1;

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_CLEAR = 2'd1,
        OP_POS   = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    localparam logic [0:0] REG_MAX_NORM = 1'b0;
    localparam logic [0:0] REG_ENABLE   = 1'b1;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] heading;
    } in_word_t;

    typedef struct packed {
        logic               ref_valid;
        logic signed [31:0] ref_x;
        logic signed [31:0] ref_y;
        logic signed [31:0] ref_z;
        logic signed [31:0] ref_heading;
        logic [6:0]         queue_count;
        logic               count_changed;
        logic               push_dropped;
    } out_word_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_DIFF,
        ST_SQ,
        ST_CMP,
        ST_SQRT,
        ST_MUL,
        ST_DIV,
        ST_ADD,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic        start;
        logic [67:0] num;
        logic [34:0] den;
    } div_req_t;

    function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
        if (v > 35'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -35'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

endpackage

// ----- hdl/wpsl_div.sv -----
module wpsl_div
    import wpsl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  div_req_t    req,
    output logic        busy,
    output logic [33:0] quot
);

    logic [67:0] num_reg, num_next;
    logic [35:0] rem_reg, rem_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [34:0] den_reg, den_next;
    logic [35:0] trial;

    always_comb
    begin
        num_next = num_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        den_next = den_reg;
        trial    = {rem_reg[34:0], num_reg[67]};
        if (req.start)
        begin
            num_next = req.num;
            rem_next = '0;
            den_next = req.den;
            cnt_next = 7'd68;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 7'd1;
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = trial - {1'b0, den_reg};
                num_next = {num_reg[66:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                num_next = {num_reg[66:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign busy = (cnt_reg != '0);
    assign quot = num_reg[33:0];

endmodule

// ----- hdl/waypoint_step_limited_reference_core.sv -----
// channel | signals                      | accepted when
// in      | in_valid/in_ready/in_data    | in_valid && in_ready
// out     | out_valid/out_ready/out_data | out_valid && out_ready
// cfg     | cfg_we/cfg_index/cfg_data    | cfg_we
// push, clear, unused code or idle position update: straight from IDLE to DONE
// position update that pops: READ, DIFF, SQ, CMP, DONE; one that steps also runs the
// 35-step square root and three divisions on one restoring divider
// (no divisions when the distance and the norm are both zero); one item at a time
// reset clears queue pointers and counts; store contents stay undefined
// a finished word waits in the output register; the next word is built
// meanwhile and only stalls in the last state while the previous one waits
module waypoint_step_limited_reference_core
    import wpsl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_word_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_data,
    input  logic      cfg_we,
    input  logic      cfg_index,
    input  logic [31:0] cfg_data
);

    state_t state_reg, state_next;
    in_word_t item_reg, item_next;
    logic [127:0] store [QUEUE_DEPTH];
    logic [127:0] rd_reg;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] count_reg, count_next, rep_reg, rep_next;
    logic [31:0] norm_reg;
    logic        en_reg;
    logic signed [32:0] d_reg [3];
    logic [67:0] s_reg, s_next;
    logic [33:0] r_reg, r_next;
    logic [5:0]  bit_reg, bit_next;
    logic [1:0]  k_reg, k_next;
    logic [67:0] prod_reg, prod_next;
    logic signed [31:0] ref_reg [3];
    logic        has_out_reg, has_out_next;
    out_word_t   out_reg, out_next;
    out_word_t   res_reg, res_next;
    logic        wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic [CNT_W-1:0] slot;
    logic [32:0] mag_k;
    logic [33:0] cand;
    logic [33:0] mul_a;
    logic [33:0] mul_b;
    logic [67:0] mul_p;
    logic        div_busy;
    logic [33:0] quot;
    div_req_t    dreq;
    logic signed [34:0] sum_k;
    logic signed [34:0] step_k;
    logic [1:0]  sq_k;
    logic        div_go_reg;

    wpsl_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .busy(div_busy), .quot(quot));

    assign slot   = {1'b0, head_reg} + count_reg;
    assign wr_idx = slot[IDX_W-1:0];
    assign sq_k   = k_reg;
    assign mag_k  = d_reg[sq_k][32] ? 33'(-d_reg[sq_k]) : 33'(d_reg[sq_k]);
    assign cand   = r_reg | (34'd1 << bit_reg);

    // one shared multiplier
    always_comb
    begin
        mul_a = 34'(mag_k);
        mul_b = 34'(mag_k);
        case (state_reg)
            ST_CMP:
            begin
                mul_a = 34'(norm_reg);
                mul_b = 34'(norm_reg);
            end
            ST_SQRT:
            begin
                mul_a = cand;
                mul_b = cand;
            end
            ST_MUL:
            begin
                mul_a = 34'(mag_k);
                mul_b = 34'(norm_reg);
            end
            default: ;
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (in_valid && in_ready)
                state_next = (op_t'(in_data.operation) == OP_POS && count_reg != '0 && en_reg)
                    ? ST_READ : ST_DONE;
            ST_READ: state_next = ST_DIFF;
            ST_DIFF: state_next = ST_SQ;
            ST_SQ:   if (k_reg == 2'd2) state_next = ST_CMP;
            ST_CMP:  state_next = (s_reg >= mul_p) ? ST_SQRT : ST_DONE;
            ST_SQRT: if (bit_reg == '0) state_next = (r_next == '0) ? ST_ADD : ST_MUL;
            ST_MUL:  state_next = ST_DIV;
            ST_DIV:  if (!div_busy && !dreq.start) state_next = ST_ADD;
            ST_ADD:  if (k_reg == 2'd2) state_next = ST_DONE;
                     else state_next = (r_reg == '0) ? ST_ADD : ST_MUL;
            ST_DONE: if (!has_out_reg || out_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        item_next = item_reg; head_next = head_reg; count_next = count_reg;
        rep_next = rep_reg; s_next = s_reg; r_next = r_reg; bit_next = bit_reg;
        k_next = k_reg; prod_next = prod_reg; has_out_next = has_out_reg;
        out_next = out_reg; res_next = res_reg; wr_en = 1'b0;
        step_k = '0; sum_k = '0;
        if (has_out_reg && out_ready)
            has_out_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    item_next = in_data;
                    res_next = '0;
                    case (op_t'(in_data.operation))
                        OP_PUSH:
                        begin
                            if (count_reg >= CNT_W'(QUEUE_DEPTH))
                                res_next.push_dropped = 1'b1;
                            else
                            begin
                                wr_en = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_CLEAR:
                        begin
                            count_next = '0;
                            head_next = '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_DIFF:
            begin
                s_next = '0;
                k_next = '0;
            end
            ST_SQ:
            begin
                s_next = s_reg + mul_p;
                k_next = (k_reg == 2'd2) ? 2'd0 : k_reg + 2'd1;
                r_next = '0;
                bit_next = 6'd34;
            end
            ST_CMP:
            begin
                if (s_reg < mul_p)
                begin
                    if (count_reg == CNT_W'(1))
                    begin
                        res_next.ref_valid = 1'b1;
                        res_next.ref_x = rd_reg[127:96];
                        res_next.ref_y = rd_reg[95:64];
                        res_next.ref_z = rd_reg[63:32];
                        res_next.ref_heading = rd_reg[31:0];
                        count_next = '0;
                        head_next = '0;
                    end
                    else
                    begin
                        head_next = head_reg + 1'b1;
                        count_next = count_reg - 1'b1;
                    end
                end
            end
            ST_SQRT:
            begin
                if (s_reg >= mul_p)
                    r_next = cand;
                bit_next = bit_reg - 6'd1;
            end
            ST_MUL: prod_next = mul_p;
            ST_ADD:
            begin
                if (r_reg != '0)
                    step_k = d_reg[sq_k][32] ? -35'(quot) : 35'(quot);
                sum_k = 35'(ref_reg[sq_k]) + step_k;
                k_next = k_reg + 2'd1;
                case (k_reg)
                    2'd0: res_next.ref_x = sat32(sum_k);
                    2'd1: res_next.ref_y = sat32(sum_k);
                    default: res_next.ref_z = sat32(sum_k);
                endcase
                res_next.ref_heading = rd_reg[31:0];
                res_next.ref_valid = 1'b1;
            end
            ST_DONE:
            begin
                if (!has_out_reg || out_ready)
                begin
                    has_out_next = 1'b1;
                    out_next = res_reg;
                    out_next.queue_count = 7'(count_reg);
                    out_next.count_changed = (count_reg != rep_reg);
                    rep_next = count_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            div_go_reg <= 1'b0;
        else
            div_go_reg <= (state_reg == ST_MUL);
    end

    always_comb
    begin
        dreq.start = div_go_reg;
        dreq.num = prod_reg;
        dreq.den = 35'(r_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            head_reg <= '0;
            count_reg <= '0;
            rep_reg <= '0;
            has_out_reg <= 1'b0;
            norm_reg <= 32'd65536;
            en_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg <= head_next;
            count_reg <= count_next;
            rep_reg <= rep_next;
            has_out_reg <= has_out_next;
            if (cfg_we && cfg_index == REG_MAX_NORM)
                norm_reg <= cfg_data;
            if (cfg_we && cfg_index == REG_ENABLE)
                en_reg <= cfg_data[0];
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        s_reg <= s_next;
        r_reg <= r_next;
        bit_reg <= bit_next;
        k_reg <= k_next;
        prod_reg <= prod_next;
        out_reg <= out_next;
        res_reg <= res_next;
        if (wr_en)
            store[wr_idx] <= {in_data.pos_x, in_data.pos_y, in_data.pos_z, in_data.heading};
        rd_reg <= store[head_reg];
        if (state_reg == ST_DIFF)
        begin
            d_reg[0] <= 33'(signed'(rd_reg[127:96])) - 33'(item_reg.pos_x);
            d_reg[1] <= 33'(signed'(rd_reg[95:64])) - 33'(item_reg.pos_y);
            d_reg[2] <= 33'(signed'(rd_reg[63:32])) - 33'(item_reg.pos_z);
            ref_reg[0] <= item_reg.pos_x;
            ref_reg[1] <= item_reg.pos_y;
            ref_reg[2] <= item_reg.pos_z;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = has_out_reg;
    assign out_data  = out_reg;

endmodule

// ----- hdl/wpsl_checker.sv -----
module wpsl_checker
    import wpsl_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input out_word_t out_data
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output word changed while stalled");

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.queue_count <= 7'(QUEUE_DEPTH))
        else $error("count above depth");

    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.ref_valid |-> out_data.ref_x == '0 && out_data.ref_heading == '0)
        else $error("reference not zero");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready after accept");

endmodule

bind waypoint_step_limited_reference_core wpsl_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data));

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

module testbench
    import wpsl_pkg::*;
();

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    in_word_t    in_data;
    logic        out_valid;
    logic        out_ready;
    out_word_t   out_data;
    logic        cfg_we;
    logic        cfg_index;
    logic [31:0] cfg_data;

    waypoint_step_limited_reference_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    typedef struct {
        bit        reconf;
        logic [31:0] norm;
        bit        enable;
        in_word_t  w;
        bit        typed;
        out_word_t e;
    } dir_row_t;

    // waypoint follower state
    logic signed [31:0] wp_x [QUEUE_DEPTH];
    logic signed [31:0] wp_y [QUEUE_DEPTH];
    logic signed [31:0] wp_z [QUEUE_DEPTH];
    logic signed [31:0] wp_yaw [QUEUE_DEPTH];
    int          head_slot;
    int          wp_count;
    int          last_count;
    logic [31:0] step_norm;
    bit          follow_on;

    out_word_t   pending_refs[$];
    int          mismatches;
    int          send_idle_pct;
    int          recv_idle_pct;
    dir_row_t    rows[$];

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic logic signed [31:0] clamp32(input logic signed [71:0] v);
        if (v > 72'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -72'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    function automatic out_word_t next_ref(input in_word_t w);
        out_word_t          r;
        logic signed [32:0] d [3];
        logic signed [31:0] p [3];
        logic signed [31:0] h [3];
        logic [127:0]       mg;
        logic [127:0]       s;
        logic [127:0]       root;
        logic [127:0]       c;
        logic [127:0]       q;
        int                 slot;
        r = '0;
        p[0] = w.pos_x;
        p[1] = w.pos_y;
        p[2] = w.pos_z;
        case (op_t'(w.operation))
            OP_PUSH:
            begin
                if (wp_count >= QUEUE_DEPTH)
                    r.push_dropped = 1'b1;
                else
                begin
                    slot = (head_slot + wp_count) % QUEUE_DEPTH;
                    wp_x[slot] = w.pos_x;
                    wp_y[slot] = w.pos_y;
                    wp_z[slot] = w.pos_z;
                    wp_yaw[slot] = w.heading;
                    wp_count++;
                end
            end
            OP_CLEAR:
            begin
                wp_count = 0;
                head_slot = 0;
            end
            OP_POS:
            begin
                if (wp_count > 0 && follow_on)
                begin
                    h[0] = wp_x[head_slot];
                    h[1] = wp_y[head_slot];
                    h[2] = wp_z[head_slot];
                    s = '0;
                    for (int k = 0; k < 3; k++)
                    begin
                        d[k] = 33'(h[k]) - 33'(p[k]);
                        mg = d[k] < 0 ? 128'(-d[k]) : 128'(d[k]);
                        s = s + mg * mg;
                    end
                    if (s >= 128'(step_norm) * 128'(step_norm))
                    begin
                        root = '0;
                        for (int b = 34; b >= 0; b--)
                        begin
                            c = root | (128'd1 << b);
                            if (c * c <= s)
                                root = c;
                        end
                        r.ref_x = p[0];
                        r.ref_y = p[1];
                        r.ref_z = p[2];
                        for (int k = 0; k < 3; k++)
                        begin
                            q = '0;
                            if (root != 0)
                            begin
                                mg = d[k] < 0 ? 128'(-d[k]) : 128'(d[k]);
                                q = (mg * 128'(step_norm)) / root;
                            end
                            if (d[k] < 0)
                                p[k] = clamp32(72'(p[k]) - $signed({1'b0, q[70:0]}));
                            else
                                p[k] = clamp32(72'(p[k]) + $signed({1'b0, q[70:0]}));
                        end
                        r.ref_x = p[0];
                        r.ref_y = p[1];
                        r.ref_z = p[2];
                        r.ref_heading = wp_yaw[head_slot];
                        r.ref_valid = 1'b1;
                    end
                    else if (wp_count == 1)
                    begin
                        r.ref_x = h[0];
                        r.ref_y = h[1];
                        r.ref_z = h[2];
                        r.ref_heading = wp_yaw[head_slot];
                        r.ref_valid = 1'b1;
                        wp_count = 0;
                        head_slot = 0;
                    end
                    else
                    begin
                        head_slot = (head_slot + 1) % QUEUE_DEPTH;
                        wp_count--;
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.queue_count = 7'(wp_count);
        r.count_changed = (wp_count != last_count);
        last_count = wp_count;
        return r;
    endfunction

    function automatic logic signed [31:0] near_coord(input logic signed [31:0] base);
        logic signed [31:0] off;
        off = $signed($urandom) >>> $urandom_range(8, 31);
        return base + off;
    endfunction

    function automatic in_word_t random_word();
        in_word_t w;
        int       pick;
        w.pos_x = $urandom;
        w.pos_y = $urandom;
        w.pos_z = $urandom;
        w.heading = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 45)
        begin
            w.operation = OP_PUSH;
            if ($urandom_range(0, 9) < 7)
            begin
                w.pos_x = near_coord(0);
                w.pos_y = near_coord(0);
                w.pos_z = near_coord(0);
            end
        end
        else if (pick < 92)
        begin
            w.operation = OP_POS;
            if (wp_count > 0 && $urandom_range(0, 9) < 7)
            begin
                w.pos_x = wp_x[head_slot];
                w.pos_y = wp_y[head_slot];
                w.pos_z = wp_z[head_slot];
                if ($urandom_range(0, 4) != 0)
                begin
                    w.pos_x = near_coord(w.pos_x);
                    w.pos_y = near_coord(w.pos_y);
                    w.pos_z = near_coord(w.pos_z);
                end
            end
        end
        else if (pick < 96)
            w.operation = OP_CLEAR;
        else
            w.operation = OP_NONE;
        return w;
    endfunction

    task automatic send_word(input in_word_t w, input bit typed, input out_word_t e);
        out_word_t p;
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= w;
        do
            @(posedge clk);
        while (!in_ready);
        p = next_ref(w);
        pending_refs = {pending_refs, (typed ? e : p)};
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_refs.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        if (idx == REG_MAX_NORM)
            step_norm = val;
        else
            follow_on = val[0];
    endtask

    task automatic configure(input logic [31:0] norm, input bit enable);
        drain();
        write_reg(REG_MAX_NORM, norm);
        write_reg(REG_ENABLE, 32'(enable));
        cfg_we <= 1'b0;
    endtask

    task automatic add_row(input dir_row_t r);
        rows = {rows, r};
    endtask

    function automatic dir_row_t row(input bit reconf, input logic [31:0] norm,
                                     input bit enable, input op_t op,
                                     input logic [31:0] x, input logic [31:0] y,
                                     input logic [31:0] z, input logic [31:0] hd,
                                     input bit typed, input out_word_t e);
        dir_row_t r;
        r.reconf = reconf;
        r.norm = norm;
        r.enable = enable;
        r.w = '{op, x, y, z, hd};
        r.typed = typed;
        r.e = e;
        return r;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        out_word_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_refs.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: %p", out_data);
            end
            else
            begin
                e = pending_refs.pop_front();
                if (out_data.ref_valid !== e.ref_valid || out_data.ref_x !== e.ref_x ||
                    out_data.ref_y !== e.ref_y || out_data.ref_z !== e.ref_z ||
                    out_data.ref_heading !== e.ref_heading ||
                    out_data.queue_count !== e.queue_count ||
                    out_data.count_changed !== e.count_changed ||
                    out_data.push_dropped !== e.push_dropped)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", e, out_data);
                end
            end
        end
    end

    initial
    begin
        #60ms;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        out_word_t z;
        logic [31:0] norms [6];
        z = '0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_MAX_NORM;
        cfg_data = '0;
        mismatches = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        head_slot = 0;
        wp_count = 0;
        last_count = 0;
        step_norm = 32'd65536;
        follow_on = 1'b0;

        add_row(row(1, 32'd65536, 1, OP_POS, 5, 5, 5, 0, 1, z));
        add_row(row(0, 0, 0, OP_PUSH, 0, 0, 0, 32'h7fffffff, 1,
                    '{1'b0, 0, 0, 0, 0, 7'd1, 1'b1, 1'b0}));
        add_row(row(0, 0, 0, OP_POS, 32'h80000000, 0, 0, 0, 0, z));
        add_row(row(0, 0, 0, OP_POS, 0, 0, 0, 0, 0, z));
        add_row(row(0, 0, 0, OP_NONE, 32'hffffffff, 1, 2, 3, 1, z));
        add_row(row(0, 0, 0, OP_PUSH, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                    32'h80000000, 1, '{1'b0, 0, 0, 0, 0, 7'd1, 1'b1, 1'b0}));
        add_row(row(0, 0, 0, OP_PUSH, 32'h80000000, 32'h7fffffff, 32'h80000000,
                    32'h7fffffff, 1, '{1'b0, 0, 0, 0, 0, 7'd2, 1'b1, 1'b0}));
        add_row(row(0, 0, 0, OP_POS, 32'h80000000, 32'h7fffffff, 32'h80000000,
                    0, 0, z));
        add_row(row(0, 0, 0, OP_CLEAR, 0, 0, 0, 0, 1,
                    '{1'b0, 0, 0, 0, 0, 7'd0, 1'b1, 1'b0}));
        add_row(row(0, 0, 0, OP_PUSH, 3 << 16, 4 << 16, 0, 7, 1,
                    '{1'b0, 0, 0, 0, 0, 7'd1, 1'b1, 1'b0}));
        add_row(row(0, 0, 0, OP_POS, 0, 0, 0, 0, 0, z));
        add_row(row(0, 0, 0, OP_PUSH, 3 << 16, 4 << 16, 12 << 16, 1, 0, z));
        add_row(row(0, 0, 0, OP_POS, 3 << 16, 4 << 16, 1000, 0, 0, z));
        add_row(row(1, 32'd0, 1, OP_POS, 3 << 16, 4 << 16, 12 << 16, 0, 0, z));
        add_row(row(0, 0, 0, OP_POS, 0, 0, 0, 0, 0, z));
        add_row(row(1, 32'hffffffff, 0, OP_POS, 0, 0, 0, 0, 1,
                    '{1'b0, 0, 0, 0, 0, 7'd1, 1'b0, 1'b0}));
        add_row(row(1, 32'hffffffff, 1, OP_POS, 32'h80000000, 32'h80000000,
                    32'h80000000, 0, 0, z));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            if (rows[i].reconf)
                configure(rows[i].norm, rows[i].enable);
            send_word(rows[i].w, rows[i].typed, rows[i].e);
        end

        norms = '{32'd65536, 32'hffffffff, 32'd0, 32'd1 << 20, 32'd4096, 32'd65536};
        for (int ph = 0; ph < 6; ph++)
        begin
            configure(ph == 5 ? $urandom : norms[ph], ph != 3);
            send_idle_pct = (ph < 2) ? 10 : (ph < 4) ? 81 : 0;
            recv_idle_pct = (ph < 2) ? 81 : (ph < 4) ? 10 : 0;
            if (ph == 1)
            begin
                for (int k = 0; k < 70; k++)
                    send_word('{OP_PUSH, near_coord(0), near_coord(0), near_coord(0),
                                $urandom}, 0, z);
            end
            for (int k = 0; k < 145; k++)
            begin
                if (ph == 2 && k == 70)
                    drain();
                send_word(random_word(), 0, z);
            end
        end

        drain();
        repeat (400) @(posedge clk);
        if (mismatches == 0 && pending_refs.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
